### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

### hdl/lcdx_pkg.sv
package lcdx_pkg;

	// Display geometry.
	localparam int LINE_LENGTH = 16;
	localparam int DISP_CELLS  = 2 * LINE_LENGTH;
	localparam int POS_W       = $clog2(DISP_CELLS);

	// Payload widths.
	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 2;
	localparam int COL_W  = 5;
	localparam int BYTE_W = 8;

	localparam logic [COL_W:0] LINE_LEN_COL = (COL_W + 1)'(LINE_LENGTH);

	// Command codes on the input channel.
	typedef enum logic [CMD_W-1:0] {
		CMD_PRINT      = 3'd0,
		CMD_SET_CURSOR = 3'd1,
		CMD_HOME       = 3'd2,
		CMD_CLEAR      = 3'd3,
		CMD_DISP_ON    = 3'd4,
		CMD_DISP_OFF   = 3'd5
	} cmd_t;

	// Controller instruction bytes.
	localparam logic [7:0] LCD_ON          = 8'h0C;
	localparam logic [7:0] LCD_OFF         = 8'h08;
	localparam logic [7:0] INSTR_CLEAR     = 8'h01;
	localparam logic [7:0] INSTR_HOME      = 8'h02;
	localparam logic [7:0] LCD_DDRAM       = 8'h80;
	localparam logic [7:0] LCD_ROW2_OFFSET = 8'h40;

	// Expander byte bit positions.
	localparam int BIT_RS = 0;
	localparam int BIT_EN = 2;
	localparam int BIT_BL = 3;

	// One classified command: one or two controller bytes.
	typedef struct packed {
		logic [7:0] byte_a;
		logic       rs_a;
		logic [7:0] byte_b;
		logic       rs_b;
		logic       two;
	} job_t;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Configuration port.
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_BACKLIGHT = '0;

endpackage

### hdl/char_lcd_i2c_expander_writer.sv
// Character LCD writer for a 2x16 display in 4-bit mode behind an I2C
// port expander. Each input transaction carries one command (print a
// character, set the cursor, home, clear, display on, display off) and
// yields a stream of expander bytes on the output channel, four per
// controller byte: high nibble with EN high then low, then the low nibble
// the same way. The final byte of a command carries last. Unknown command
// codes are taken and produce nothing.
// Both channels use valid and stall; a transaction completes at a clock edge
// with valid high and stall low. The first byte of a command passes through
// the queue and the output register. The back end sends one byte per cycle
// while out_stall is low; a command gives four bytes, or eight when a print
// crosses a line end and an address command is added. A two-entry command
// queue sits between the decoder and the byte sequencer, so new commands are
// taken while earlier bytes are still waiting; in_stall rises only when the
// queue is full. If the receiver stalls, the current byte holds and the
// queue fills. Reset clears the cursor to the upper left corner, empties
// the queue and sets backlight_on to 1. The APB port holds backlight_on at
// byte address 0 and should only be written while the block is idle.
module char_lcd_i2c_expander_writer (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lcdx_pkg::PADDR_W-1:0] paddr,
	input  logic [lcdx_pkg::PDATA_W-1:0] pwdata,
	output logic [lcdx_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// Command input
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lcdx_pkg::CMD_W-1:0]   command,
	input  logic [lcdx_pkg::CHAR_W-1:0]  char_code,
	input  logic [lcdx_pkg::ROW_W-1:0]   cursor_row,
	input  logic [lcdx_pkg::COL_W-1:0]   cursor_col,
	// Expander byte output
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lcdx_pkg::BYTE_W-1:0]  expander_byte,
	output logic                         last
);
	import lcdx_pkg::*;

	logic                 backlight_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 push;
	logic                 pop;
	job_t                 push_job;
	job_t                 head;
	q_status_t            q_status;

	// Register file: a single bit, always ready, no wait states.
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_BACKLIGHT)) begin
			backlight_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_BACKLIGHT) begin
			prdata[0] = backlight_q;
		end
	end

	// Front end decodes commands and tracks the cursor position.
	lcdx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.char_code  (char_code),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	// Short queue that lets the two halves stall independently.
	lcdx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// Back end serializes each job into expander bytes.
	lcdx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.backlight_on  (backlight_q),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.expander_byte (expander_byte),
		.last          (last)
	);

endmodule

### hdl/lcdx_front.sv
module lcdx_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lcdx_pkg::CMD_W-1:0]  command,
	input  logic [lcdx_pkg::CHAR_W-1:0] char_code,
	input  logic [lcdx_pkg::ROW_W-1:0]  cursor_row,
	input  logic [lcdx_pkg::COL_W-1:0]  cursor_col,
	input  lcdx_pkg::q_status_t         q_status,
	output logic                        push,
	output lcdx_pkg::job_t              push_job
);
	import lcdx_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic             accept;
	logic             set_ok;
	logic             row2;
	logic [7:0]       set_byte;
	logic [POS_W-1:0] set_pos;
	logic [POS_W-1:0] pos_inc;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// Cursor command decode: rows 1 and 2, columns 1 to the line length.
	assign row2     = (cursor_row == ROW_W'(2));
	assign set_ok   = ((cursor_row == ROW_W'(1)) || row2) && (cursor_col != '0)
		&& ({1'b0, cursor_col} <= LINE_LEN_COL);
	assign set_byte = LCD_DDRAM + (row2 ? LCD_ROW2_OFFSET : 8'h00) + (8'(cursor_col) - 8'd1);
	assign set_pos  = (row2 ? POS_W'(LINE_LENGTH) : POS_W'(0)) + POS_W'(cursor_col)
		- POS_W'(1);
	assign pos_inc  = (pos_q == POS_W'(DISP_CELLS - 1)) ? '0 : pos_q + POS_W'(1);

	always_comb begin
		push_job = '0;
		push     = 1'b0;
		pos_d    = pos_q;
		if (accept) begin
			case (cmd_t'(command))
				CMD_PRINT: begin
					push  = 1'b1;
					pos_d = pos_inc;
					if (pos_q == POS_W'(LINE_LENGTH)) begin
						// Start of line 2: move the address there first.
						push_job.byte_a = LCD_DDRAM | LCD_ROW2_OFFSET;
						push_job.byte_b = char_code;
						push_job.rs_b   = 1'b1;
						push_job.two    = 1'b1;
					end else begin
						push_job.byte_a = char_code;
						push_job.rs_a   = 1'b1;
						if (pos_inc == '0) begin
							// Wrapped past the last cell: back to line 1.
							push_job.byte_b = LCD_DDRAM;
							push_job.two    = 1'b1;
						end
					end
				end
				CMD_SET_CURSOR: begin
					push = 1'b1;
					if (set_ok) begin
						push_job.byte_a = set_byte;
						pos_d           = set_pos;
					end else begin
						push_job.byte_a = INSTR_HOME;
						pos_d           = '0;
					end
				end
				CMD_HOME: begin
					push            = 1'b1;
					push_job.byte_a = INSTR_HOME;
					pos_d           = '0;
				end
				CMD_CLEAR: begin
					push            = 1'b1;
					push_job.byte_a = INSTR_CLEAR;
					pos_d           = '0;
				end
				CMD_DISP_ON: begin
					push            = 1'b1;
					push_job.byte_a = LCD_ON;
				end
				CMD_DISP_OFF: begin
					push            = 1'b1;
					push_job.byte_a = LCD_OFF;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_d;
		end
	end

endmodule

### hdl/lcdx_queue.sv
`include "assert_macros.svh"

module lcdx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lcdx_pkg::job_t      push_job,
	input  logic                pop,
	output lcdx_pkg::job_t      head,
	output lcdx_pkg::q_status_t status
);
	import lcdx_pkg::*;

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_push_when_full, clk, arst_n, push && status.full)
	`ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && status.empty)
	`ASSERT_NEVER(a_count_overrun, clk, arst_n, count_q > Q_CNT_W'(Q_DEPTH))

endmodule

### hdl/lcdx_back.sv
`include "assert_macros.svh"

module lcdx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        backlight_on,
	input  lcdx_pkg::job_t              head,
	input  lcdx_pkg::q_status_t         q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lcdx_pkg::BYTE_W-1:0] expander_byte,
	output logic                        last
);
	import lcdx_pkg::*;

	// Byte counter within a job: bit 2 picks the controller byte, bit 1 the
	// nibble, bit 0 the enable phase (high first, then low).
	logic [2:0]        cnt_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              head_valid;
	logic              load;
	logic              emit;
	logic              last_byte;
	logic [7:0]        lcd_byte;
	logic              rs;
	logic [3:0]        nibble;
	logic [BYTE_W-1:0] exp_byte;

	assign head_valid = !q_status.empty;
	assign load       = !out_valid_q || !out_stall;
	assign emit       = load && head_valid;
	assign last_byte  = (cnt_q == (head.two ? 3'd7 : 3'd3));
	assign pop        = emit && last_byte;

	assign lcd_byte = cnt_q[2] ? head.byte_b : head.byte_a;
	assign rs       = cnt_q[2] ? head.rs_b : head.rs_a;
	assign nibble   = cnt_q[1] ? lcd_byte[3:0] : lcd_byte[7:4];

	always_comb begin
		exp_byte         = '0;
		exp_byte[7:4]    = nibble;
		exp_byte[BIT_BL] = backlight_on;
		exp_byte[BIT_EN] = !cnt_q[0];
		exp_byte[BIT_RS] = rs;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= exp_byte;
			last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				cnt_q <= last_byte ? 3'd0 : cnt_q + 3'd1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign expander_byte = byte_q;
	assign last          = last_q;

	`ASSERT_CLK(a_second_byte_needs_two, clk, arst_n, (head_valid && cnt_q[2]) |-> head.two)
	`ASSERT_CLK(a_pop_shows_last, clk, arst_n, pop |=> (out_valid_q && last_q))

endmodule
